>>> src/pda_pkg.sv
// Package with sizes, item kinds, status codes, match constants and the state machine type.
package pda_pkg;
	localparam int NUM_STATES = 16;

	localparam logic [2:0] KIND_CLEAR = 3'd0;
	localparam logic [2:0] KIND_ALPHA = 3'd1;
	localparam logic [2:0] KIND_TRANS = 3'd2;
	localparam logic [2:0] KIND_SYM   = 3'd3;
	localparam logic [2:0] KIND_END   = 3'd4;

	localparam logic [3:0] ST_OK       = 4'd0;
	localparam logic [3:0] ST_ACCEPT   = 4'd1;
	localparam logic [3:0] ST_NO_START = 4'd2;
	localparam logic [3:0] ST_UNKNOWN  = 4'd3;
	localparam logic [3:0] ST_STUCK    = 4'd4;
	localparam logic [3:0] ST_NOTFINAL = 4'd5;
	localparam logic [3:0] ST_OVERFLOW = 4'd6;
	localparam logic [3:0] ST_FULL     = 4'd7;
	localparam logic [3:0] ST_LOADED   = 4'd8;

	localparam logic [7:0] END_CODE   = 8'h4C;
	localparam logic [7:0] EMPTY_CODE = 8'h5A;

	localparam logic CFG_START = 1'b0;
	localparam logic CFG_FINAL = 1'b1;

	typedef struct packed {
		logic [7:0] rd;
		logic [7:0] sk;
		logic [3:0] to;
		logic       pe;
		logic [7:0] pb;
		logic       po;
	} rule_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CLEAR = 5'b00010,
		S_READ  = 5'b00100,
		S_MATCH = 5'b01000,
		S_OUT   = 5'b10000
	} fsm_t;
endpackage

>>> src/pda_ram.sv
// Generic simple dual-port RAM with registered read.
module pda_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> src/pushdown_automaton_recognizer.sv
// Pushdown automaton recognizer with the rules, the alphabet and the stack held in RAMs.
// Loads and ignored kinds go from S_IDLE to S_OUT, which registers the result; no new item is
// taken until the block is back in S_IDLE. A symbol or end item scans one rule a cycle in S_MATCH;
// an unknown symbol ends in S_READ and a frozen run goes straight to S_OUT.
// A clear sweeps the alphabet RAM; the same sweep follows reset.
// Reset clears counts, stack pointer, flags and configuration; rule and stack RAMs keep contents.
module pushdown_automaton_recognizer
	import pda_pkg::*;
#(
	parameter int TRANS_PER_STATE = 4,
	parameter int STACK_DEPTH     = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] kind,
	input  logic [7:0] symbol,
	input  logic [3:0] from_state,
	input  logic [7:0] read_symbol,
	input  logic [7:0] stack_symbol,
	input  logic [3:0] to_state,
	input  logic       push_enable,
	input  logic [7:0] push_byte,
	input  logic       pop_enable,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] status,
	output logic [3:0] current_state,
	output logic [6:0] stack_depth,
	output logic [7:0] stack_top,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [3:0] cfg_data
);
	localparam int CW = $clog2(TRANS_PER_STATE + 1);
	localparam int RD = NUM_STATES * TRANS_PER_STATE;
	localparam int RW = $clog2(RD);
	localparam int SW = $clog2(STACK_DEPTH);
	localparam int PW = $clog2(STACK_DEPTH + 1);
	localparam int RULE_W = $bits(rule_t);

	fsm_t            st_q;
	logic [CW-1:0]   cnt_q [NUM_STATES];
	logic [PW-1:0]   sp_q;
	logic [3:0]      run_q;
	logic [2:0]      flags_q;
	logic [3:0]      start_q, final_q;
	logic [7:0]      top_q;
	logic [2:0]      kind_q;
	logic [7:0]      sym_q;
	logic [CW-1:0]   idx_q;
	logic            hit_q;
	logic [7:0]      clr_q;
	logic            clr_ack_q;

	logic            rwe;
	logic [RW-1:0]   rwaddr, rraddr;
	logic [RULE_W-1:0] rwdata, rrdata;
	rule_t           rule;
	logic            swe;
	logic [SW-1:0]   swaddr, sraddr;
	logic [7:0]      srdata;
	logic            awe, awdata, ardata;
	logic [7:0]      aaddr;

	logic            from_ok;
	logic [CW-1:0]   from_cnt, cur_cnt;
	logic            run_ok;
	logic [3:0]      flag_code;

	assign rule = rule_t'(rrdata);
	assign from_ok = 32'(from_state) < NUM_STATES;
	assign from_cnt = from_ok ? cnt_q[from_state[$clog2(NUM_STATES)-1:0]] : '0;
	assign run_ok = 32'(run_q) < NUM_STATES;
	assign cur_cnt = run_ok ? cnt_q[run_q[$clog2(NUM_STATES)-1:0]] : '0;
	assign in_ready = (st_q == S_IDLE) && (!out_valid || out_ready);

	always_comb begin
		if (flags_q[0]) flag_code = ST_UNKNOWN;
		else if (flags_q[1]) flag_code = ST_STUCK;
		else if (flags_q[2]) flag_code = ST_OVERFLOW;
		else flag_code = ST_OK;
	end

	assign rwe = in_valid && in_ready && kind == KIND_TRANS && from_ok
		&& 32'(from_cnt) < TRANS_PER_STATE;
	assign rwaddr = RW'(32'(from_state) * TRANS_PER_STATE + 32'(from_cnt));
	assign rwdata = RULE_W'({read_symbol, stack_symbol, to_state, push_enable, push_byte,
		pop_enable});
	assign rraddr = RW'(32'(run_q) * TRANS_PER_STATE + 32'(idx_q));

	pda_ram #(.WIDTH(RULE_W), .DEPTH(RD)) u_rules (
		.clk(clk), .we(rwe), .waddr(rwaddr), .wdata(rwdata),
		.raddr(rraddr), .rdata(rrdata)
	);

	assign aaddr = (st_q == S_CLEAR) ? clr_q : symbol;
	assign awe = (st_q == S_CLEAR) || (in_valid && in_ready && kind == KIND_ALPHA);
	assign awdata = (st_q != S_CLEAR);

	pda_ram #(.WIDTH(1), .DEPTH(256)) u_alpha (
		.clk(clk), .we(awe), .waddr(aaddr), .wdata(awdata),
		.raddr(aaddr), .rdata(ardata)
	);

	logic            rm, sm, fire_now;
	logic [PW-1:0]   sp_m1;
	assign sp_m1 = sp_q - PW'(1);
	assign rm = (kind_q == KIND_END) ? (rule.rd == END_CODE) : (rule.rd == sym_q);
	assign sm = (sp_q == '0) ? (rule.sk == EMPTY_CODE) : (rule.sk == top_q);
	assign fire_now = (st_q == S_MATCH) && !hit_q && (idx_q <= cur_cnt) && rm && sm;
	assign swe = fire_now && rule.pe && 32'(sp_q) < STACK_DEPTH;
	assign swaddr = sp_q[SW-1:0];
	assign sraddr = sp_m1[SW-1:0];

	pda_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(swe), .waddr(swaddr), .wdata(rule.pb),
		.raddr(sraddr), .rdata(srdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLEAR;
			for (int i = 0; i < NUM_STATES; i++) cnt_q[i] <= '0;
			sp_q <= '0;
			run_q <= '0;
			flags_q <= '0;
			start_q <= '0;
			final_q <= '0;
			out_valid <= 1'b0;
			idx_q <= '0;
			hit_q <= 1'b0;
			clr_q <= '0;
			clr_ack_q <= 1'b0;
			top_q <= '0;
			kind_q <= KIND_CLEAR;
			sym_q <= '0;
			status <= ST_OK;
			current_state <= '0;
			stack_depth <= '0;
			stack_top <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == CFG_START) begin
					start_q <= cfg_data;
					run_q <= cfg_data;
					sp_q <= '0;
					flags_q <= '0;
				end else begin
					final_q <= cfg_data;
				end
			end
			case (st_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						kind_q <= kind;
						sym_q <= symbol;
						case (kind)
							KIND_CLEAR: begin
								for (int i = 0; i < NUM_STATES; i++) cnt_q[i] <= '0;
								run_q <= start_q;
								sp_q <= '0;
								flags_q <= '0;
								clr_ack_q <= 1'b1;
								status <= ST_LOADED;
								st_q <= S_CLEAR;
							end
							KIND_ALPHA: begin
								status <= ST_LOADED;
								st_q <= S_OUT;
							end
							KIND_TRANS: begin
								if (rwe) begin
									cnt_q[from_state[$clog2(NUM_STATES)-1:0]] <=
										from_cnt + CW'(1);
									status <= ST_LOADED;
								end else begin
									status <= ST_FULL;
								end
								st_q <= S_OUT;
							end
							KIND_SYM, KIND_END: begin
								idx_q <= '0;
								hit_q <= 1'b0;
								if (flags_q != '0) st_q <= S_OUT;
								else st_q <= S_READ;
							end
							default: begin
								status <= ST_OK;
								st_q <= S_OUT;
							end
						endcase
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + 8'd1;
					if (clr_q == 8'hFF) begin
						clr_ack_q <= 1'b0;
						st_q <= clr_ack_q ? S_OUT : S_IDLE;
					end
				end
				S_READ: begin
					if (!hit_q && kind_q == KIND_SYM && !ardata) begin
						flags_q <= flags_q | 3'b001;
						st_q <= S_OUT;
					end else begin
						top_q <= srdata;
						idx_q <= idx_q + CW'(1);
						st_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					if (idx_q > cur_cnt || hit_q) begin
						if (!hit_q) flags_q <= flags_q | 3'b010;
						st_q <= S_OUT;
					end else if (rm && sm) begin
						hit_q <= 1'b1;
						run_q <= rule.to;
						if (rule.pe) begin
							if (32'(sp_q) >= STACK_DEPTH) flags_q <= flags_q | 3'b100;
							else sp_q <= sp_q + PW'(1);
						end else if (rule.po && sp_q != '0) begin
							sp_q <= sp_m1;
						end
						st_q <= S_READ;
					end else begin
						idx_q <= idx_q + CW'(1);
						if (32'(idx_q) >= TRANS_PER_STATE) begin
							flags_q <= flags_q | 3'b010;
							st_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					out_valid <= 1'b1;
					current_state <= run_q;
					stack_depth <= 7'(sp_q);
					stack_top <= (sp_q == '0) ? 8'd0 : srdata;
					st_q <= S_IDLE;
					if (kind_q == KIND_SYM) begin
						status <= flag_code;
					end else if (kind_q == KIND_END) begin
						if (!(32'(start_q) < NUM_STATES) ||
							cnt_q[start_q[$clog2(NUM_STATES)-1:0]] == '0) status <= ST_NO_START;
						else if (flags_q != '0) status <= flag_code;
						else if (run_q != final_q) status <= ST_NOTFINAL;
						else status <= ST_ACCEPT;
						run_q <= start_q;
						sp_q <= '0;
						flags_q <= '0;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> test/pushdown_automaton_recognizer_tb.sv
// Self-checking testbench for the pushdown automaton recognizer.
module pushdown_automaton_recognizer_tb
	import pda_pkg::*;
();

	localparam int N_ST = 16;
	localparam int N_TR = 4;
	localparam int STK  = 64;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] symbol;
		logic [3:0] from_state;
		logic [7:0] read_symbol;
		logic [7:0] stack_symbol;
		logic [3:0] to_state;
		logic       push_enable;
		logic [7:0] push_byte;
		logic       pop_enable;
	} item_t;

	typedef struct packed {
		logic [3:0] status;
		logic [3:0] current_state;
		logic [6:0] stack_depth;
		logic [7:0] stack_top;
	} verdict_t;

	typedef struct {
		item_t    it;
		logic     known;
		verdict_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] kind = '0;
	logic [7:0] symbol = '0;
	logic [3:0] from_state = '0;
	logic [7:0] read_symbol = '0;
	logic [7:0] stack_symbol = '0;
	logic [3:0] to_state = '0;
	logic push_enable = 1'b0;
	logic [7:0] push_byte = '0;
	logic pop_enable = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] status;
	logic [3:0] current_state;
	logic [6:0] stack_depth;
	logic [7:0] stack_top;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_START;
	logic [3:0] cfg_data = '0;

	pushdown_automaton_recognizer i_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor state.
	rule_t      rules [N_ST*N_TR];
	int         rule_cnt [N_ST];
	bit         alpha [256];
	logic [7:0] stk [STK];
	int         sp;
	logic [3:0] cur;
	bit         f_unk, f_stuck, f_ovf;
	logic [3:0] cfg_start_q, cfg_final_q;

	verdict_t expected_q [$];
	int errors = 0;
	bit calm = 1'b0;

	function automatic void restart_run();
		cur = cfg_start_q;
		sp = 0;
		f_unk = 0;
		f_stuck = 0;
		f_ovf = 0;
	endfunction

	function automatic logic [3:0] pending_code();
		if (f_unk) return ST_UNKNOWN;
		if (f_stuck) return ST_STUCK;
		if (f_ovf) return ST_OVERFLOW;
		return ST_OK;
	endfunction

	function automatic void take_rule(logic [7:0] sym, bit at_end);
		rule_t r;
		bit rm, sm;
		for (int i = 0; i < rule_cnt[cur]; i++) begin
			r = rules[cur*N_TR + i];
			rm = at_end ? (r.rd == END_CODE) : (r.rd == sym);
			sm = (sp == 0) ? (r.sk == EMPTY_CODE) : (r.sk == stk[sp-1]);
			if (rm && sm) begin
				cur = r.to;
				if (r.pe) begin
					if (sp >= STK) f_ovf = 1;
					else begin
						stk[sp] = r.pb;
						sp++;
					end
				end else if (r.po && sp > 0) begin
					sp--;
				end
				return;
			end
		end
		f_stuck = 1;
	endfunction

	function automatic verdict_t run_item(item_t it);
		verdict_t v;
		logic [3:0] st;
		rule_t r;
		st = ST_OK;
		case (it.kind)
			KIND_CLEAR: begin
				foreach (rule_cnt[i]) rule_cnt[i] = 0;
				foreach (alpha[i]) alpha[i] = 0;
				restart_run();
				st = ST_LOADED;
			end
			KIND_ALPHA: begin
				alpha[it.symbol] = 1;
				st = ST_LOADED;
			end
			KIND_TRANS: begin
				if (rule_cnt[it.from_state] >= N_TR) st = ST_FULL;
				else begin
					r.rd = it.read_symbol;
					r.sk = it.stack_symbol;
					r.to = it.to_state;
					r.pe = it.push_enable;
					r.pb = it.push_byte;
					r.po = it.pop_enable;
					rules[it.from_state*N_TR + rule_cnt[it.from_state]] = r;
					rule_cnt[it.from_state]++;
					st = ST_LOADED;
				end
			end
			KIND_SYM: begin
				if (!(f_unk || f_stuck || f_ovf)) begin
					if (!alpha[it.symbol]) f_unk = 1;
					else take_rule(it.symbol, 0);
				end
				st = pending_code();
			end
			KIND_END: begin
				if (!(f_unk || f_stuck || f_ovf)) take_rule(8'h00, 1);
				if (rule_cnt[cfg_start_q] == 0) st = ST_NO_START;
				else if (f_unk || f_stuck || f_ovf) st = pending_code();
				else if (cur != cfg_final_q) st = ST_NOTFINAL;
				else st = ST_ACCEPT;
			end
			default: st = ST_OK;
		endcase
		v.status = st;
		v.current_state = cur;
		v.stack_depth = sp[6:0];
		v.stack_top = sp ? stk[sp-1] : 8'h00;
		if (it.kind == KIND_END) restart_run();
		return v;
	endfunction

	// Result checker.
	always @(posedge clk) begin
		verdict_t got, w;
		if (out_valid && out_ready) begin
			got = '{status, current_state, stack_depth, stack_top};
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
			end else begin
				w = expected_q.pop_front();
				if (got !== w) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: want st=%0d cs=%0d d=%0d top=%h %s",
							w.status, w.current_state, w.stack_depth, w.stack_top,
							$sformatf("got st=%0d cs=%0d d=%0d top=%h",
							got.status, got.current_state, got.stack_depth, got.stack_top));
				end
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 19);
	end

	task automatic send(item_t it, bit known, verdict_t want);
		verdict_t v;
		v = run_item(it);
		if (known && v !== want) begin
			errors++;
			if (errors <= 10) $display("table row disagrees: want %h model %h", want, v);
		end
		expected_q = {expected_q, v};
		if (!calm) begin
			while ($urandom_range(99) < 19) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		{kind, symbol, from_state, read_symbol, stack_symbol, to_state,
			push_enable, push_byte, pop_enable} <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [3:0] val);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_START) begin
			cfg_start_q = val;
			restart_run();
		end else cfg_final_q = val;
	endtask

	function automatic item_t mk(logic [2:0] k, logic [7:0] s);
		item_t it;
		it = '0;
		it.kind = k;
		it.symbol = s;
		return it;
	endfunction

	function automatic item_t mk_rule(logic [3:0] f, logic [7:0] rd, logic [7:0] sk,
			logic [3:0] t, logic pe, logic [7:0] pb, logic po);
		item_t it;
		it = '{KIND_TRANS, 8'h00, f, rd, sk, t, pe, pb, po};
		return it;
	endfunction

	function automatic item_t rand_item();
		item_t it;
		it = '{3'($urandom), 8'($urandom), 4'($urandom), 8'($urandom), 8'($urandom),
			4'($urandom), 1'($urandom), 8'($urandom), 1'($urandom)};
		return it;
	endfunction

	task automatic random_program(int nsym);
		logic [7:0] syms [4];
		item_t it;
		verdict_t z;
		z = '0;
		send(mk(KIND_CLEAR, 8'($urandom)), 0, z);
		foreach (syms[i]) begin
			syms[i] = 8'($urandom);
			send(mk(KIND_ALPHA, syms[i]), 0, z);
		end
		repeat ($urandom_range(6, 14)) begin
			it = mk_rule(4'($urandom_range(3)),
				($urandom_range(3) == 0) ? END_CODE : syms[2'($urandom)],
				($urandom_range(2) == 0) ? EMPTY_CODE : syms[2'($urandom)],
				4'($urandom_range(3)), 1'($urandom), syms[2'($urandom)], 1'($urandom));
			if ($urandom_range(15) == 0) it = rand_item();
			send(it, 0, z);
		end
		repeat (nsym) begin
			it = mk(KIND_SYM, ($urandom_range(15) == 0) ? 8'($urandom) : syms[2'($urandom)]);
			if ($urandom_range(7) == 0) it.kind = KIND_END;
			if ($urandom_range(40) == 0) it = rand_item();
			send(it, 0, z);
		end
		send(mk(KIND_END, 8'h00), 0, z);
	endtask

	row_t rows [$];

	initial begin
		int sent;
		rows = '{
			'{mk(KIND_END, 8'h00), 1, '{ST_NO_START, 4'd0, 7'd0, 8'h00}},
			'{mk(KIND_SYM, 8'hFF), 1, '{ST_UNKNOWN, 4'd0, 7'd0, 8'h00}},
			'{mk(3'd7, 8'h00), 1, '{ST_OK, 4'd0, 7'd0, 8'h00}},
			'{mk(3'd5, 8'hAA), 1, '{ST_OK, 4'd0, 7'd0, 8'h00}},
			'{mk(3'd6, 8'h55), 1, '{ST_OK, 4'd0, 7'd0, 8'h00}},
			'{mk(KIND_END, 8'h00), 1, '{ST_NO_START, 4'd0, 7'd0, 8'h00}},
			'{mk(KIND_ALPHA, 8'h00), 1, '{ST_LOADED, 4'd0, 7'd0, 8'h00}},
			'{mk(KIND_ALPHA, 8'hFF), 1, '{ST_LOADED, 4'd0, 7'd0, 8'h00}},
			'{mk_rule(4'd0, 8'h00, EMPTY_CODE, 4'd15, 1'b1, 8'hFF, 1'b1), 1,
				'{ST_LOADED, 4'd0, 7'd0, 8'h00}},
			'{mk_rule(4'd15, 8'hFF, 8'hFF, 4'd0, 1'b0, 8'h00, 1'b1), 0, '0},
			'{mk_rule(4'd0, END_CODE, 8'hFF, 4'd0, 1'b0, 8'h00, 1'b0), 0, '0},
			'{mk_rule(4'd0, 8'h00, 8'h00, 4'd0, 1'b0, 8'h00, 1'b0), 0, '0},
			'{mk_rule(4'd0, 8'hFF, 8'hFF, 4'd0, 1'b1, 8'h01, 1'b0), 0, '0},
			'{mk_rule(4'd0, 8'h00, 8'h00, 4'd0, 1'b0, 8'h00, 1'b0), 1,
				'{ST_FULL, 4'd0, 7'd0, 8'h00}},
			'{mk(KIND_SYM, 8'h00), 0, '0},
			'{mk(KIND_SYM, 8'hFF), 0, '0},
			'{mk(KIND_END, 8'h00), 0, '0},
			'{mk(KIND_SYM, 8'h00), 0, '0},
			'{mk(KIND_SYM, 8'h00), 0, '0},
			'{mk(KIND_SYM, 8'h11), 0, '0},
			'{mk(KIND_END, 8'h00), 0, '0},
			'{mk(KIND_CLEAR, 8'h00), 1, '{ST_LOADED, 4'd0, 7'd0, 8'h00}}
		};
		foreach (rule_cnt[i]) rule_cnt[i] = 0;
		foreach (alpha[i]) alpha[i] = 0;
		cfg_start_q = '0;
		cfg_final_q = '0;
		restart_run();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) send(rows[i].it, rows[i].known, rows[i].want);
		write_reg(CFG_FINAL, 4'd15);
		write_reg(CFG_START, 4'd15);
		// Rules that push on symbol 28h and pop at the end, driven past full stack depth for overflow.
		send(mk(KIND_ALPHA, 8'h28), 0, '0);
		send(mk_rule(4'd15, 8'h28, EMPTY_CODE, 4'd15, 1'b1, 8'h28, 1'b0), 0, '0);
		send(mk_rule(4'd15, 8'h28, 8'h28, 4'd15, 1'b1, 8'h28, 1'b0), 0, '0);
		send(mk_rule(4'd15, END_CODE, 8'h28, 4'd15, 1'b0, 8'h00, 1'b1), 0, '0);
		repeat (66) send(mk(KIND_SYM, 8'h28), 0, '0);
		send(mk(KIND_END, 8'h00), 0, '0);
		send(mk(KIND_SYM, 8'h28), 0, '0);
		send(mk(KIND_END, 8'h00), 0, '0);
		sent = 0;
		for (int ph = 0; sent < 950; ph++) begin
			write_reg(CFG_START, 4'($urandom_range(3)));
			write_reg(CFG_FINAL, (ph % 5 == 0) ? 4'd0 : 4'($urandom_range(3)));
			calm = (ph == 4);
			for (int k = 0; k < 3; k++) begin
				random_program($urandom_range(4, 20));
				sent += 30;
			end
		end
		in_valid <= 1'b0;
		calm = 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

	initial begin
		#30000000;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
